@@ rtl/mcdb_pkg.sv @@
// Shared types and constants of the multichannel input debouncer.
package mcdb_pkg;

   // Fixed width of every channel bit field on the item ports.
   localparam int FIELD_WIDTH = 18;

   // Configuration port widths.
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 18;

   // Filter threshold register width.
   localparam int THRESHOLD_WIDTH = 8;

   // Register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FILTER_THRESHOLD   = 4'd0,
      CSR_REPORT_ENABLE_MASK = 4'd1
   } csr_index_type;

   // Reset values of the registers.
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET = 8'd10;
   localparam logic [FIELD_WIDTH-1:0]     REPORT_RESET    = '0;

   // What one lane hands to the merge stage for the current item.
   typedef struct packed {
      logic level;
      logic known;
      logic changed;
   } lane_status_type;

endpackage

@@ rtl/mcdb_if.sv @@
// Channel interfaces: sample input, result output and configuration write.
interface mcdb_req_if;
   import mcdb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] raw_samples;

   modport source (output valid, output raw_samples, input ready);
   modport sink   (input valid, input raw_samples, output ready);
endinterface

interface mcdb_rsp_if;
   import mcdb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] debounced_levels;
   logic [FIELD_WIDTH-1:0] known_mask;
   logic [FIELD_WIDTH-1:0] changed_mask;
   logic [FIELD_WIDTH-1:0] report_mask;

   modport source (output valid, output debounced_levels, output known_mask,
                   output changed_mask, output report_mask, input ready);
   modport sink   (input valid, input debounced_levels, input known_mask,
                   input changed_mask, input report_mask, output ready);
endinterface

interface mcdb_csr_if;
   import mcdb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mcdb_lane.sv @@
// One debounce lane: previous sample, stability counter and filtered level.
module mcdb_lane #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic                             sample,
   input  logic [COUNT_WIDTH-1:0]           threshold,
   output mcdb_pkg::lane_status_type        status
);
   import mcdb_pkg::*;

   logic                   prev_sample_ff, prev_sample_in;
   logic                   prev_valid_ff, prev_valid_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   level_ff, level_in;
   logic                   known_ff, known_in;
   logic                   changed;
   logic                   same;
   logic [COUNT_WIDTH-1:0] count_inc;

   assign same      = prev_valid_ff && (prev_sample_ff == sample);
   assign count_inc = count_ff + COUNT_WIDTH'(1);

   always_comb begin
      prev_sample_in = sample;
      prev_valid_in  = 1'b1;
      count_in       = count_ff;
      level_in       = level_ff;
      known_in       = known_ff;
      changed        = 1'b0;
      if (same) begin
         if (count_ff < threshold) begin
            count_in = count_inc;
            if ((count_inc == threshold) && (!known_ff || (level_ff != sample))) begin
               level_in = sample;
               known_in = 1'b1;
               changed  = 1'b1;
            end
         end else begin
            // saturated, also after the threshold was lowered
            count_in = threshold;
         end
      end else begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= 1'b0;
         prev_valid_ff  <= 1'b0;
         count_ff       <= '0;
         level_ff       <= 1'b0;
         known_ff       <= 1'b0;
      end else if (load) begin
         prev_sample_ff <= prev_sample_in;
         prev_valid_ff  <= prev_valid_in;
         count_ff       <= count_in;
         level_ff       <= level_in;
         known_ff       <= known_in;
      end
   end

   assign status.level   = level_in & known_in;
   assign status.known   = known_in;
   assign status.changed = changed;

endmodule

@@ rtl/mcdb_merge.sv @@
// Merge stage: packs lane results into masks and holds the output item.
module mcdb_merge #(
   parameter int CHANNELS = 18
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      load,
   input  mcdb_pkg::lane_status_type [CHANNELS-1:0]  status,
   input  logic [mcdb_pkg::FIELD_WIDTH-1:0]          report_enable,
   mcdb_rsp_if.source                                rsp
);
   import mcdb_pkg::*;

   logic                   valid_ff, valid_in;
   logic [FIELD_WIDTH-1:0] levels_ff, levels_in;
   logic [FIELD_WIDTH-1:0] known_ff, known_in;
   logic [FIELD_WIDTH-1:0] changed_ff, changed_in;
   logic [FIELD_WIDTH-1:0] report_ff, report_in;

   // channels above the field width drop out, missing channels read as 0
   for (genvar j = 0; j < FIELD_WIDTH; j++) begin : g_bit
      if (j < CHANNELS) begin : g_lane
         assign levels_in[j]  = status[j].level;
         assign known_in[j]   = status[j].known;
         assign changed_in[j] = status[j].changed;
      end else begin : g_none
         assign levels_in[j]  = 1'b0;
         assign known_in[j]   = 1'b0;
         assign changed_in[j] = 1'b0;
      end
   end

   assign report_in = changed_in & report_enable;
   assign valid_in  = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         levels_ff  <= levels_in;
         known_ff   <= known_in;
         changed_ff <= changed_in;
         report_ff  <= report_in;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.debounced_levels = levels_ff;
   assign rsp.known_mask       = known_ff;
   assign rsp.changed_mask     = changed_ff;
   assign rsp.report_mask      = report_ff;

endmodule

@@ rtl/multichannel_input_debouncer.sv @@
// Multichannel input debouncer top level: config registers, lanes and merge stage.
// A result item is registered and appears in the cycle after its sample item is accepted.
// Throughput: one item per cycle; the output register takes a new item whenever
//   it is empty or its item is taken in the same cycle.
// Reset (synchronous, active high): all lane state cleared, threshold 10,
//   report mask 0, output register empty.
module multichannel_input_debouncer #(
   parameter int CHANNELS    = 18,
   parameter int COUNT_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   mcdb_req_if.sink   req_ch,
   mcdb_rsp_if.source rsp_ch,
   mcdb_csr_if.sink   csr_ch
);
   import mcdb_pkg::*;

   // comparison width wide enough for both the register and the counter
   localparam int CMP_WIDTH = (COUNT_WIDTH > THRESHOLD_WIDTH) ? COUNT_WIDTH : THRESHOLD_WIDTH;
   localparam logic [CMP_WIDTH-1:0] COUNT_MAX = CMP_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);

   // configuration registers
   logic [THRESHOLD_WIDTH-1:0] threshold_ff, threshold_in;
   logic [FIELD_WIDTH-1:0]     report_en_ff, report_en_in;
   logic                       csr_write;

   // datapath control
   logic                       accept;
   logic [CMP_WIDTH-1:0]       threshold_wide;
   logic [COUNT_WIDTH-1:0]     threshold_eff;
   lane_status_type [CHANNELS-1:0] status;

   // ---------------------------------------------------------------------
   // Configuration port: always ready; writes to unknown indexes are dropped
   // ---------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      threshold_in = threshold_ff;
      report_en_in = report_en_ff;
      if (csr_write) begin
         case (csr_ch.index)
            CSR_FILTER_THRESHOLD:   threshold_in = csr_ch.data[THRESHOLD_WIDTH-1:0];
            CSR_REPORT_ENABLE_MASK: report_en_in = csr_ch.data[FIELD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         report_en_ff <= REPORT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         report_en_ff <= report_en_in;
      end
   end

   // ---------------------------------------------------------------------
   // Effective threshold: clamp to what the counter can hold.
   // A zero threshold keeps every counter at zero, so nothing is adopted.
   // ---------------------------------------------------------------------
   assign threshold_wide = CMP_WIDTH'(threshold_ff);
   assign threshold_eff  = (threshold_wide < COUNT_MAX) ?
                           threshold_wide[COUNT_WIDTH-1:0] : COUNT_MAX[COUNT_WIDTH-1:0];

   // ---------------------------------------------------------------------
   // Handshake: the output register decouples the two sides, so a new item
   // enters while the last result is being taken.
   // ---------------------------------------------------------------------
   assign req_ch.ready = !rsp_ch.valid || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------------
   // One lane per channel; channels past the field width see a 0 sample
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic sample;
      if (i < FIELD_WIDTH) begin : g_pin
         assign sample = req_ch.raw_samples[i];
      end else begin : g_tied
         assign sample = 1'b0;
      end

      mcdb_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .sample    (sample),
         .threshold (threshold_eff),
         .status    (status[i])
      );
   end

   // ---------------------------------------------------------------------
   // Merge lanes into the result item
   // ---------------------------------------------------------------------
   mcdb_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .status        (status),
      .report_enable (report_en_ff),
      .rsp           (rsp_ch)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // an accepted item always shows up as a result in the next cycle
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted item did not produce a result");

   // a stalled result blocks new input
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input accepted while result stalled");

   // reports are a subset of changes, changes a subset of known channels
   a_report_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (((rsp_ch.report_mask & ~rsp_ch.changed_mask) == '0) &&
                        ((rsp_ch.changed_mask & ~rsp_ch.known_mask) == '0)))
      else $error("report or change mask outside its superset");

   // a threshold write lands in the register
   a_threshold_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_ch.index == CSR_FILTER_THRESHOLD)) |=>
         (threshold_ff == $past(csr_ch.data[THRESHOLD_WIDTH-1:0])))
      else $error("threshold write lost");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the multichannel input debouncer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcdb_pkg::*;

   // Block configuration under test
   localparam int CHANNELS    = 18;
   localparam int COUNT_WIDTH = 8;
   localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;

   localparam logic [FIELD_WIDTH-1:0]     FIELD_ONES    = {FIELD_WIDTH{1'b1}};
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_MAX = {THRESHOLD_WIDTH{1'b1}};

   // Register indexes with no register behind them; writes there must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_UNMAPPED = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_UNMAPPED  = 4'd15;

   // Cycles to let pass once nothing is pending
   localparam int SETTLE_CYCLES = 4;
   // Hard stop, far above the slowest legal run
   localparam int RUN_LIMIT_NS  = 2_000_000;

   // One result item, as the block should present it
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] levels;
      logic [FIELD_WIDTH-1:0] known;
      logic [FIELD_WIDTH-1:0] changed;
      logic [FIELD_WIDTH-1:0] report;
   } tick_result_type;

   logic clock;
   logic reset;

   mcdb_req_if req_ch ();
   mcdb_rsp_if rsp_ch ();
   mcdb_csr_if csr_ch ();

   multichannel_input_debouncer #(
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // ------------------------------------------------------------------
   // Debounce predictor: registers plus per-channel filter state
   // ------------------------------------------------------------------
   logic [THRESHOLD_WIDTH-1:0] model_threshold;
   logic [FIELD_WIDTH-1:0]     model_report_mask;

   logic                   last_sample [CHANNELS];
   logic                   last_seen   [CHANNELS];  // a sample has arrived
   logic [COUNT_WIDTH-1:0] stable_count[CHANNELS];
   logic                   filt_level  [CHANNELS];
   logic                   level_known [CHANNELS];

   // Expected results, oldest first
   tick_result_type pending_results[$];

   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;

   function automatic void clear_filter_model();
      model_threshold   = THRESHOLD_RESET;
      model_report_mask = REPORT_RESET;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         last_sample[ch]  = 1'b0;
         last_seen[ch]    = 1'b0;
         stable_count[ch] = '0;
         filt_level[ch]   = 1'b0;
         level_known[ch]  = 1'b0;
      end
   endfunction

   // Advance every channel by one scan tick and return the expected result.
   function automatic tick_result_type debounce_tick(input logic [FIELD_WIDTH-1:0] raw);
      tick_result_type        res;
      logic [COUNT_WIDTH-1:0] eff_thr;
      logic                   smp;
      logic                   same;
      res = '0;
      // threshold clamps to what the counter can hold
      eff_thr = (int'(model_threshold) < COUNT_MAX) ? COUNT_WIDTH'(model_threshold)
                                                    : COUNT_WIDTH'(COUNT_MAX);
      for (int ch = 0; ch < CHANNELS; ch++) begin
         smp  = (ch < FIELD_WIDTH) ? raw[ch] : 1'b0;
         // first sample after reset never counts as a stable pair
         same = last_seen[ch] && (last_sample[ch] == smp);
         last_sample[ch] = smp;
         last_seen[ch]   = 1'b1;
         if (same) begin
            if (stable_count[ch] < eff_thr) begin
               stable_count[ch] = stable_count[ch] + 1'b1;
               if (stable_count[ch] == eff_thr &&
                   (!level_known[ch] || filt_level[ch] != smp)) begin
                  filt_level[ch]  = smp;
                  level_known[ch] = 1'b1;
                  if (ch < FIELD_WIDTH)
                     res.changed[ch] = 1'b1;
               end
            end else begin
               // saturated, or threshold lowered under the count: no adoption
               stable_count[ch] = eff_thr;
            end
         end else begin
            stable_count[ch] = '0;
         end
         if (ch < FIELD_WIDTH) begin
            res.known[ch]  = level_known[ch];
            res.levels[ch] = level_known[ch] & filt_level[ch];
         end
      end
      res.report = res.changed & model_report_mask;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [FIELD_WIDTH-1:0] want,
                                  input logic [FIELD_WIDTH-1:0] got);
      $display("ERROR at %0t ns: %s, expected %05h, got %05h", $time, what, want, got);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #RUN_LIMIT_NS;
      $display("Mismatches found");
      $finish;
   end

   // Result side back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   // ------------------------------------------------------------------
   // Monitor: all handshakes are sampled at the rising edge. Register
   // writes and accepted items update the predictor, results are checked
   // against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tick_result_type want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_FILTER_THRESHOLD:   model_threshold = csr_ch.data[THRESHOLD_WIDTH-1:0];
               CSR_REPORT_ENABLE_MASK: model_report_mask = csr_ch.data[FIELD_WIDTH-1:0];
               default: ;  // unmapped index, dropped
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            pending_results.push_back(debounce_tick(req_ch.raw_samples));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with no item pending, debounced_levels", '0,
                               rsp_ch.debounced_levels);
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.debounced_levels !== want.levels)
                  report_mismatch("debounced_levels", want.levels, rsp_ch.debounced_levels);
               if (rsp_ch.known_mask !== want.known)
                  report_mismatch("known_mask", want.known, rsp_ch.known_mask);
               if (rsp_ch.changed_mask !== want.changed)
                  report_mismatch("changed_mask", want.changed, rsp_ch.changed_mask);
               if (rsp_ch.report_mask !== want.report)
                  report_mismatch("report_mask", want.report, rsp_ch.report_mask);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers: everything changes on the falling edge
   // ------------------------------------------------------------------

   // Send one sample item, with random gaps ahead of it; returns once taken.
   task automatic send_samples(input logic [FIELD_WIDTH-1:0] raw);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.raw_samples = raw;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Stop sending, wait for every pending result, then let the pipe settle.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Reset threshold of 10: first sample clears the count, the 11th equal
   // sample adopts, the 12th sits on a saturated counter.
   task automatic test_default_threshold();
      repeat (12) send_samples(18'h2AAAA);
   endtask

   // Both registers, high data bits beyond the threshold width, unmapped
   // indexes, and a threshold lowered under running counts.
   task automatic test_register_writes();
      wait_idle();
      write_csr(CSR_REPORT_ENABLE_MASK, FIELD_ONES);
      write_csr(CSR_FILTER_THRESHOLD, 18'h3FF01);   // only the low byte counts
      write_csr(CSR_FIRST_UNMAPPED, '1);
      write_csr(CSR_LAST_UNMAPPED, 18'h00155);
      send_samples(FIELD_ONES);
      send_samples(FIELD_ONES);
      send_samples('0);
      send_samples('0);
      send_samples(18'h15555);
      send_samples(18'h15555);
   endtask

   // Zero threshold: counts stay at zero, nothing is ever adopted.
   task automatic test_zero_threshold();
      wait_idle();
      write_csr(CSR_FILTER_THRESHOLD, '0);
      write_csr(CSR_REPORT_ENABLE_MASK, 18'h0F0F0);
      repeat (3) send_samples(FIELD_ONES);
   endtask

   // Saturate at 3, then drop the threshold to 1 under the saturated count.
   task automatic test_lowered_threshold();
      wait_idle();
      write_csr(CSR_FILTER_THRESHOLD, 18'd3);
      repeat (5) send_samples(18'h0F0F0);
      wait_idle();
      write_csr(CSR_FILTER_THRESHOLD, 18'd1);
      send_samples(18'h0F0F0);
   endtask

   // ------------------------------------------------------------------
   // Random phase: segments of runs of stable samples with bounce and
   // noise; each segment starts from idle with fresh register settings.
   // ------------------------------------------------------------------
   task automatic run_random_phase(input int n_items, input int idle_pct,
                                   input int stall_pct);
      int                         sent;
      int                         seg_end;
      int                         run_cap;
      int                         run_len;
      logic [THRESHOLD_WIDTH-1:0] thr;
      logic [CSR_DATA_WIDTH-1:0]  thr_word;
      logic [FIELD_WIDTH-1:0]     mask;
      logic [FIELD_WIDTH-1:0]     base;
      logic [FIELD_WIDTH-1:0]     raw;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         // sender holds off until every result is back before reprogramming
         wait_idle();
         case ($urandom_range(11))
            0:       thr = '0;
            1:       thr = THRESHOLD_MAX;
            default: thr = THRESHOLD_WIDTH'($urandom_range(1, 6));
         endcase
         case ($urandom_range(3))
            0:       mask = '0;
            1:       mask = FIELD_ONES;
            default: mask = FIELD_WIDTH'($urandom);
         endcase
         thr_word = CSR_DATA_WIDTH'($urandom);
         thr_word[THRESHOLD_WIDTH-1:0] = thr;
         write_csr(CSR_FILTER_THRESHOLD, thr_word);
         write_csr(CSR_REPORT_ENABLE_MASK, mask);
         if ($urandom_range(3) == 0)
            write_csr(CSR_INDEX_WIDTH'($urandom_range(CSR_FIRST_UNMAPPED, CSR_LAST_UNMAPPED)),
                      CSR_DATA_WIDTH'($urandom));
         // run lengths are capped a little above the threshold, at most 40, so adoption can happen
         run_cap = (int'(thr) + 4 > 40) ? 40 : int'(thr) + 4;
         seg_end = sent + $urandom_range(30, 60);
         base    = FIELD_WIDTH'($urandom);
         while (sent < seg_end && sent < n_items) begin
            run_len = $urandom_range(1, run_cap);
            repeat (run_len) begin
               case ($urandom_range(9))
                  0:       raw = FIELD_WIDTH'($urandom);                   // noise
                  1, 2:    raw = base ^ FIELD_WIDTH'($urandom & $urandom & $urandom); // bounce
                  default: raw = base;
               endcase
               send_samples(raw);
               sent++;
            end
            // new level: either a fresh pattern or a few channels toggled
            if ($urandom_range(1))
               base = FIELD_WIDTH'($urandom);
            else
               base ^= FIELD_WIDTH'($urandom & $urandom);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.raw_samples = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_FILTER_THRESHOLD;
      csr_ch.data        = '0;
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      clear_filter_model();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_threshold();
      test_register_writes();
      test_zero_threshold();
      test_lowered_threshold();

      run_random_phase(180, 32, 71);
      run_random_phase(180, 71, 32);
      run_random_phase(190, 0, 0);

      wait_idle();
      if (pending_results.size() != 0)
         report_mismatch("result never arrived, debounced_levels",
                         pending_results[0].levels, '0);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
